### rtl/core/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// Holds the transaction payload structs and the controller/datapath interface.
// No dependencies.
package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int COUNT_W    = PAGE_W + 1;
  localparam int ROW_BITS   = 8;
  localparam int ROW_W      = $clog2(ROW_BITS);
  localparam int NUM_ROWS   = NUM_PAGES / ROW_BITS;
  localparam int ROW_ADDR_W = $clog2(NUM_ROWS);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [PAGE_W-1:0]  first_page;
    logic [COUNT_W-1:0] span_len;
    logic [COUNT_W-1:0] align_pages;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [PAGE_W-1:0]  start_page;
    logic [COUNT_W-1:0] free_pages;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic scan_init;
    logic scan_step;
    logic take_found;
    logic set_ok;
    logic mark_init;
    logic mark_rd;
    logic load_out;
  } bpa_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       clr_last;
    logic       found;
    logic       map_end;
    logic       mark_last;
  } bpa_sts_t;

endpackage

### rtl/core/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: first-fit aligned page runs.
// Joins the controller and the datapath; depends on bpa_pkg, bpa_ctrl, bpa_datapath.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_data  (in_item_t)
//   out      output     out_valid / out_ready  out_data (out_item_t)
//
// One transaction is processed at a time; the result register lets the next one start
// while a result still waits. An allocation scans one page per cycle and then marks its run
// one map row per cycle. Free and reserve mark only the map rows that their run touches.
// After reset a clearing pass over every map row runs before the first transaction.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### rtl/core/bpa_datapath.sv
// Datapath of the bitmap page allocator: page map memory, scan and marking logic.
// Holds the free page count and the result register.
// Depends on bpa_pkg.
module bpa_datapath import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bpa_cmd_t  cmd,
  input  in_item_t  in_data,
  output bpa_sts_t  sts,
  output out_item_t out_data
);

  logic [ROW_BITS-1:0]   page_mem [NUM_ROWS];

  logic [1:0]            op_r;
  logic [PAGE_W-1:0]     first_r;
  logic [COUNT_W-1:0]    cnt_r;
  logic [COUNT_W-1:0]    align_r;
  logic [COUNT_W-1:0]    free_count_r;
  logic [PAGE_W-1:0]     page_r;
  logic [COUNT_W-1:0]    mod_r;
  logic [COUNT_W-1:0]    run_r;
  logic [PAGE_W-1:0]     base_r;
  logic [ROW_BITS-1:0]   rd_data_r;
  logic [ROW_ADDR_W-1:0] row_r;
  logic [ROW_ADDR_W-1:0] last_row_r;
  logic [ROW_ADDR_W-1:0] wr_row_r;
  logic                  wr_pend_r;
  logic [PAGE_W-1:0]     last_pg_r;
  logic                  ok_r;
  logic [PAGE_W-1:0]     start_r;
  out_item_t             out_r;

  logic                  page_bit;
  logic                  run_start;
  logic                  take;
  logic [COUNT_W-1:0]    run_inc;
  logic [COUNT_W-1:0]    mod_inc;
  logic [PAGE_W-1:0]     found_base;
  logic                  map_end;
  logic                  rd_en;
  logic [ROW_ADDR_W-1:0] rd_addr;
  logic                  mem_we;
  logic [ROW_ADDR_W-1:0] wr_addr;
  logic [ROW_BITS-1:0]   wr_data;
  logic [ROW_BITS-1:0]   marked_row;
  logic                  set_val;
  logic [COUNT_W-1:0]    room;
  logic [COUNT_W-1:0]    mark_n;
  logic [COUNT_W-1:0]    last_pg_full;
  logic [COUNT_W:0]      free_sum;
  logic [COUNT_W-1:0]    free_count_nxt;

  assign page_bit   = rd_data_r[page_r[ROW_W-1:0]];
  assign run_start  = (run_r == '0);
  assign take       = !page_bit && (!run_start || (mod_r == '0));
  assign run_inc    = run_r + COUNT_W'(1);
  assign mod_inc    = mod_r + COUNT_W'(1);
  assign found_base = run_start ? page_r : base_r;
  assign map_end    = (page_r == PAGE_W'(NUM_PAGES - 1));

  assign sts.op        = op_r;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.clr_last  = (row_r == ROW_ADDR_W'(NUM_ROWS - 1));
  assign sts.found     = take && (run_inc == cnt_r);
  assign sts.map_end   = map_end;
  assign sts.mark_last = (row_r == last_row_r);

  assign rd_en = cmd.scan_init | cmd.mark_rd |
                 (cmd.scan_step && (page_r[ROW_W-1:0] == ROW_W'(ROW_BITS - 1)) && !map_end);

  always_comb begin
    if (cmd.scan_init) begin
      rd_addr = '0;
    end else if (cmd.mark_rd) begin
      rd_addr = row_r;
    end else begin
      rd_addr = page_r[PAGE_W-1:ROW_W] + ROW_ADDR_W'(1);
    end
  end

  assign set_val = (op_r != OP_FREE);

  always_comb begin
    logic [PAGE_W-1:0] pg;
    for (int b = 0; b < ROW_BITS; b++) begin
      pg = {wr_row_r, ROW_W'(b)};
      marked_row[b] = ((pg >= first_r) && (pg <= last_pg_r)) ? set_val : rd_data_r[b];
    end
  end

  assign mem_we  = cmd.clr_step | wr_pend_r;
  assign wr_addr = cmd.clr_step ? row_r : wr_row_r;
  assign wr_data = cmd.clr_step ? '0 : marked_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= page_mem[rd_addr];
    end
  end

  assign room         = COUNT_W'(NUM_PAGES) - {1'b0, first_r};
  assign mark_n       = (cnt_r < room) ? cnt_r : room;
  assign last_pg_full = {1'b0, first_r} + mark_n - COUNT_W'(1);
  assign free_sum     = {1'b0, free_count_r} + {1'b0, mark_n};

  always_comb begin
    if (op_r == OP_FREE) begin
      free_count_nxt = (free_sum > (COUNT_W + 1)'(NUM_PAGES)) ? COUNT_W'(NUM_PAGES)
                                                              : free_sum[COUNT_W-1:0];
    end else begin
      free_count_nxt = (free_count_r > mark_n) ? (free_count_r - mark_n) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_count_r <= COUNT_W'(NUM_PAGES);
      row_r        <= '0;
      wr_pend_r    <= 1'b0;
    end else begin
      wr_pend_r <= cmd.mark_rd;
      if (cmd.clr_step || cmd.mark_rd) begin
        row_r <= row_r + ROW_ADDR_W'(1);
      end else if (cmd.mark_init) begin
        row_r <= first_r[PAGE_W-1:ROW_W];
      end
      if (cmd.mark_init) begin
        free_count_r <= free_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data.op;
      first_r <= in_data.first_page;
      cnt_r   <= in_data.span_len;
      align_r <= (in_data.align_pages == '0) ? COUNT_W'(1) : in_data.align_pages;
      ok_r    <= 1'b0;
      start_r <= '0;
    end
    if (cmd.set_ok) begin
      ok_r <= 1'b1;
    end
    if (cmd.scan_init) begin
      page_r <= '0;
      mod_r  <= '0;
      run_r  <= '0;
    end
    if (cmd.scan_step) begin
      page_r <= page_r + PAGE_W'(1);
      mod_r  <= (mod_inc == align_r) ? '0 : mod_inc;
      if (page_bit) begin
        run_r <= '0;
      end else if (take) begin
        run_r  <= run_inc;
        base_r <= found_base;
      end
    end
    if (cmd.take_found) begin
      first_r <= found_base;
      start_r <= found_base;
      ok_r    <= 1'b1;
    end
    if (cmd.mark_init) begin
      last_pg_r  <= last_pg_full[PAGE_W-1:0];
      last_row_r <= last_pg_full[PAGE_W-1:ROW_W];
    end
    if (cmd.mark_rd) begin
      wr_row_r <= row_r;
    end
    if (cmd.load_out) begin
      out_r.ok         <= ok_r;
      out_r.start_page <= start_r;
      out_r.free_pages <= free_count_r;
    end
  end

  assign out_data = out_r;

  a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= COUNT_W'(NUM_PAGES))
    else $error("free page count above page total");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_pend_r && cmd.mark_rd) |-> (wr_row_r != row_r))
    else $error("row written and read in the same cycle");

  a_found_aligned_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && sts.found) |-> (!page_bit && (run_inc == cnt_r)))
    else $error("allocation reported on a used page");

endmodule

### rtl/core/bpa_ctrl.sv
// Controller of the bitmap page allocator: sequences clearing, scan and marking.
// Drives the datapath commands and the channel handshakes.
// Depends on bpa_pkg.
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  bpa_sts_t sts,
  output bpa_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_SCAN0    = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_MARK0    = 4'd5;
  localparam logic [3:0] S_MARK_RD  = 4'd6;
  localparam logic [3:0] S_MARK_WR  = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op) inside
          OP_ALLOC: begin
            state_nxt = sts.cnt_zero ? S_RESP : S_SCAN0;
          end
          OP_FREE, OP_RESERVE: begin
            cmd.set_ok = 1'b1;
            state_nxt  = sts.cnt_zero ? S_RESP : S_MARK0;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_SCAN0: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          cmd.take_found = 1'b1;
          state_nxt      = S_MARK0;
        end else if (sts.map_end) begin
          state_nxt = S_RESP;
        end
      end
      S_MARK0: begin
        cmd.mark_init = 1'b1;
        state_nxt     = S_MARK_RD;
      end
      S_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        if (sts.mark_last) begin
          state_nxt = S_MARK_WR;
        end
      end
      S_MARK_WR: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("transaction accepted during the clearing pass");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> slot_free)
    else $error("result register overwritten before it was taken");

  a_mark_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK_RD) |=> ((state_r == S_MARK_RD) || (state_r == S_MARK_WR)))
    else $error("marking left before its final write");

endmodule
